@@ sv/tsm_pkg.sv @@
// Shared types, event codes and state encoding for the two-port timestamp matcher.
package tsm_pkg;

    localparam int HASH_W = 64;
    localparam int TIME_W = 64;

    // For a depth that is not a power of two, the hash is folded byte by byte
    // into a 32-bit value with the same remainder before the final reduction.
    localparam int FOLD_W = 8;
    localparam int FOLD_N = HASH_W / FOLD_W;
    localparam int RED_W  = 32;

    typedef enum logic [1:0] {
        EV_STORED    = 2'd0,
        EV_MATCH     = 2'd1,
        EV_COLLISION = 2'd2
    } t_event;

    typedef struct packed {
        logic              port;
        logic [HASH_W-1:0] packet_hash;
        logic [TIME_W-1:0] timestamp;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [HASH_W-1:0] match_hash;
        logic [TIME_W-1:0] time_first_port;
        logic [TIME_W-1:0] time_second_port;
    } t_out_word;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [TIME_W-1:0] time_ns;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_DECIDE
    } t_state;

endpackage

@@ sv/tsm_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
module tsm_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tsm_index.sv @@
// Reduces a packet hash to its table slot, the hash modulo the table depth.
module tsm_index #(
    parameter int DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tsm_pkg::HASH_W-1:0] i_hash,
    output logic                       o_done,
    output logic [$clog2(DEPTH)-1:0]   o_idx
);
    import tsm_pkg::*;

    localparam int  IDX_W = $clog2(DEPTH);
    localparam bit  POW2  = (DEPTH & (DEPTH - 1)) == 0;

    logic             r_done;
    logic [IDX_W-1:0] r_idx;

    generate
        if (POW2) begin : g_mask
            // A power-of-two depth keeps only the low hash bits.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_idx <= i_hash[IDX_W-1:0];
                end
            end
        end else begin : g_fold
            // Each hash byte is weighted by its power of two modulo DEPTH, which
            // keeps the remainder and brings the value below 2^31. A reciprocal
            // multiply then estimates the quotient at most one too small, so a
            // single compare and subtract finishes the remainder. The sum, the quotient
            // estimate, its product with the depth and the index are registered in turn.
            localparam logic [RED_W-1:0] DEPTH_C = RED_W'(DEPTH);
            localparam logic [RED_W-1:0] RECIP   =
                RED_W'((64'd1 << RED_W) / 64'(DEPTH));

            logic [RED_W-1:0]   w_part [FOLD_N];
            logic [RED_W-1:0]   w_sum;
            logic [2*RED_W-1:0] w_prod;
            logic [RED_W-1:0]   w_rem;
            logic [2:0]         r_v;
            logic [RED_W-1:0]   r_sum;
            logic [RED_W-1:0]   r_x;
            logic [RED_W-1:0]   r_q;
            logic [RED_W-1:0]   r_qd;

            for (genvar g = 0; g < FOLD_N; g++) begin : g_part
                localparam logic [RED_W-1:0] WEIGHT =
                    RED_W'((64'd1 << (FOLD_W * g)) % 64'(DEPTH));
                assign w_part[g] = RED_W'(i_hash[FOLD_W*g +: FOLD_W]) * WEIGHT;
            end

            always_comb begin
                w_sum = '0;
                for (int g = 0; g < FOLD_N; g++) begin
                    w_sum = w_sum + w_part[g];
                end
            end

            assign w_prod = (2*RED_W)'(r_sum) * (2*RED_W)'(RECIP);
            assign w_rem  = r_x - r_qd;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v    <= '0;
                    r_done <= 1'b0;
                end else begin
                    r_v    <= {r_v[1:0], i_start};
                    r_done <= r_v[2];
                end
                if (i_start) begin
                    r_sum <= w_sum;
                end
                if (r_v[0]) begin
                    r_x <= r_sum;
                    r_q <= w_prod[2*RED_W-1:RED_W];
                end
                if (r_v[1]) begin
                    r_qd <= r_q * DEPTH_C;
                end
                if (r_v[2]) begin
                    if (w_rem >= DEPTH_C) begin
                        r_idx <= IDX_W'(w_rem - DEPTH_C);
                    end else begin
                        r_idx <= IDX_W'(w_rem);
                    end
                end
            end
        end
    endgenerate

    assign o_done = r_done;
    assign o_idx  = r_idx;

endmodule

@@ sv/two_port_timestamp_matcher_top.sv @@
// Top level of the two-port timestamp matcher: control, tables and result register.
//
// Each input word is one packet seen on capture port 0 or 1, with its 64-bit
// hash and its timestamp; each accepted word yields exactly one result word.
// Every port owns a direct-mapped table of TABLE_DEPTH slots held in a
// synchronous RAM and addressed by the hash modulo TABLE_DEPTH. A packet first
// looks at the other port's slot: the same hash gives a match carrying both
// timestamps and empties that slot, a different nonzero hash is reported as a
// collision and the packet is dropped, and an empty slot lets the packet be
// written into its own port's slot, replacing any older entry. Timestamps in
// the result are zero unless the event is a match. The block handles one word
// at a time. When TABLE_DEPTH is a power of two a word goes through slot select,
// table read, and decide and write before the next ready; otherwise the modulo
// is first computed by a four-stage fold and reciprocal-multiply unit. After
// reset both tables are swept to empty, one slot per cycle, so the input stays
// not ready until every slot is cleared. The result sits in an output register,
// and a decision waits there only if that register still holds a word that has
// not been taken.
module two_port_timestamp_matcher_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tsm_pkg::t_in_word i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tsm_pkg::t_out_word o_out
);
    import tsm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // Control state and the packet under work.
    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_clr;
    logic              r_port;
    logic [HASH_W-1:0] r_hash;
    logic [TIME_W-1:0] r_ts;

    // Result register.
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word w_result;

    // Index unit.
    logic             w_start;
    logic             w_idx_done;
    logic [IDX_W-1:0] w_idx;

    // Table ports. Index 0 is the first port's table, index 1 the second's.
    logic             w_we [2];
    logic [IDX_W-1:0] w_waddr;
    t_slot            w_wdata;
    logic             w_re;
    t_slot            w_rdata [2];

    logic  w_accept;
    logic  w_out_free;
    logic  w_commit;
    t_slot w_other;
    logic  w_match;
    logic  w_collide;

    tsm_index #(
        .DEPTH (TABLE_DEPTH)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_hash  (i_in.packet_hash),
        .o_done  (w_idx_done),
        .o_idx   (w_idx)
    );

    for (genvar p = 0; p < 2; p++) begin : g_table
        tsm_ram #(
            .WIDTH (SLOT_W),
            .DEPTH (TABLE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[p]),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_re    (w_re),
            .i_raddr (w_idx),
            .o_rdata (w_rdata[p])
        );
    end

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // The slot of the other port decides what happens to the packet.
    assign w_other   = r_port ? w_rdata[0] : w_rdata[1];
    assign w_match   = (w_other.hash != '0) && (w_other.hash == r_hash);
    assign w_collide = (w_other.hash != '0) && (w_other.hash != r_hash);

    always_comb begin
        w_result            = '0;
        w_result.match_hash = r_hash;
        if (w_match) begin
            w_result.event_res = EV_MATCH;
            if (r_port) begin
                w_result.time_first_port  = w_other.time_ns;
                w_result.time_second_port = r_ts;
            end else begin
                w_result.time_first_port  = r_ts;
                w_result.time_second_port = w_other.time_ns;
            end
        end else if (w_collide) begin
            w_result.event_res = EV_COLLISION;
        end else begin
            w_result.event_res = EV_STORED;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (w_idx_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Outputs of the state machine: handshake, table accesses and commit.
    always_comb begin
        o_in_ready = 1'b0;
        w_start    = 1'b0;
        w_re       = 1'b0;
        w_commit   = 1'b0;
        w_we[0]    = 1'b0;
        w_we[1]    = 1'b0;
        w_waddr    = w_idx;
        w_wdata    = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_waddr = r_clr;
                w_we[0] = 1'b1;
                w_we[1] = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_start    = i_in_valid;
            end
            S_REDUCE: begin
                // The slot index is ready; read both tables at it.
                w_re = w_idx_done;
            end
            S_DECIDE: begin
                w_commit = w_out_free;
                if (w_match) begin
                    // Empty the other port's slot.
                    w_we[0] = w_out_free && r_port;
                    w_we[1] = w_out_free && !r_port;
                end else if (!w_collide) begin
                    // Store into this packet's own table.
                    w_wdata.hash    = r_hash;
                    w_wdata.time_ns = r_ts;
                    w_we[0]         = w_out_free && !r_port;
                    w_we[1]         = w_out_free && r_port;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_port <= i_in.port;
            r_hash <= i_in.packet_hash;
            r_ts   <= i_in.timestamp;
        end
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
